// File: hw/rtl/dqe_pkg.sv
// Shared types and codes for the double-ended queue.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package dqe_pkg;

  // Operation codes carried on the mode port
  localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [1:0] MODE_POP_FRONT  = 2'd1;
  localparam logic [1:0] MODE_PUSH_BACK  = 2'd2;
  localparam logic [1:0] MODE_POP_BACK   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Slot address selection for the access
  typedef enum logic [1:0] {
    ADDR_HEAD,
    ADDR_HEAD_DEC,
    ADDR_TAIL,
    ADDR_LAST
  } dqe_addr_sel_t;

  // Controller to datapath command, valid in the accept cycle
  typedef struct packed {
    dqe_addr_sel_t addr_sel;
    logic          wr;
    logic          rd;
    logic          head_dec;
    logic          head_inc;
    logic          cnt_inc;
    logic          cnt_dec;
  } dqe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
  } dqe_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/dqe_datapath.sv
// Datapath: slot memory, head index and fill count of the queue.
// Depends on dqe_pkg for the command and status structs.
`default_nettype none

module dqe_datapath
  import dqe_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dqe_cmd_t                     cmd,
  input  logic signed [31:0]           value_in,
  output dqe_stat_t                    stat,
  output logic signed [31:0]           value_out,
  output logic [$clog2(DEPTH+1)-1:0]   occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  rd_ok;
  logic [AW-1:0]         head;
  logic [CW-1:0]         count;

  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] last_sum;
  logic [AW-1:0] tail_idx;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] addr;
  logic [63:0]   in_wide;
  logic [63:0]   rd_wide;

  // wrap by compare and subtract: sums stay below twice the depth
  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign tail_sum = SW'(head) + SW'(count);
  assign last_sum = tail_sum - 1'b1;
  assign tail_idx = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign last_idx = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_HEAD:     addr = head;
      ADDR_HEAD_DEC: addr = head_dec;
      ADDR_TAIL:     addr = tail_idx;
      ADDR_LAST:     addr = last_idx;
      default:       addr = head;
    endcase
  end

  assign in_wide = 64'($unsigned(value_in));

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= in_wide[DATA_WIDTH-1:0];
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= cmd.rd;
      if (cmd.head_dec) begin
        head <= head_dec;
      end else if (cmd.head_inc) begin
        head <= head_inc;
      end
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
    end
  end

  assign stat.full  = (count == DEPTH_C);
  assign stat.empty = (count == '0);

  assign rd_wide   = 64'(rd_data);
  assign value_out = rd_ok ? $signed(rd_wide[31:0]) : 32'sd0;
  assign occupancy = count;

endmodule

`default_nettype wire

// File: hw/rtl/dqe_ctrl.sv
// Controller: accept/response state machine and operation decode.
// Depends on dqe_pkg for codes and the command and status structs.
`default_nettype none

module dqe_ctrl
  import dqe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  mode,
  input  dqe_stat_t   stat,
  output dqe_cmd_t    cmd,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t     state;
  logic       accept;
  logic [1:0] status_next;

  assign busy   = (state == S_RESP);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.addr_sel = ADDR_HEAD;
    status_next = ST_OK;
    unique case (mode)
      MODE_PUSH_FRONT: begin
        cmd.addr_sel = ADDR_HEAD_DEC;
        if (stat.full) begin
          status_next = ST_FULL;
        end else begin
          cmd.wr       = accept;
          cmd.head_dec = accept;
          cmd.cnt_inc  = accept;
        end
      end
      MODE_POP_FRONT: begin
        cmd.addr_sel = ADDR_HEAD;
        if (stat.empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.rd       = accept;
          cmd.head_inc = accept;
          cmd.cnt_dec  = accept;
        end
      end
      MODE_PUSH_BACK: begin
        cmd.addr_sel = ADDR_TAIL;
        if (stat.full) begin
          status_next = ST_FULL;
        end else begin
          cmd.wr      = accept;
          cmd.cnt_inc = accept;
        end
      end
      MODE_POP_BACK: begin
        cmd.addr_sel = ADDR_LAST;
        if (stat.empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.rd      = accept;
          cmd.cnt_dec = accept;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      status <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= accept;
          if (accept) begin
            state  <= S_RESP;
            status <= status_next;
          end
        end
        S_RESP: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/double_ended_queue.sv
// Bounded double-ended queue: the done beat follows in the cycle after accept.
// A new command is not taken until the last is through: busy stays high for the
// cycle in which the result beat is shown.
// Reset (rst, synchronous) empties the queue and zeroes the head index;
// slot contents are not cleared. The receiver cannot stall the done beat.
// Depends on dqe_pkg, dqe_ctrl and dqe_datapath.
`default_nettype none

module double_ended_queue
  import dqe_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // command side: a beat is taken when start is high and busy is low
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode,
  input  logic signed [31:0]          value_in,
  // result side: one beat per operation, marked by done
  output logic                        done,
  output logic signed [31:0]          value_out,
  output logic [1:0]                  status,
  output logic [$clog2(DEPTH+1)-1:0]  occupancy
);

  dqe_cmd_t  cmd;
  dqe_stat_t stat;

  // Controller: decodes mode against full/empty in the accept cycle and, if
  // the operation can proceed, issues one memory access plus head/count updates.
  dqe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  // Datapath: circular buffer addressed from head index and fill count.
  // Pushes write at the accept edge; pops read there and the registered
  // read data is on value_out during the done beat.
  dqe_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value_in  (value_in),
    .stat      (stat),
    .value_out (value_out),
    .occupancy (occupancy)
  );

endmodule

`default_nettype wire

// File: hw/rtl/dqe_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on dqe_pkg for the status codes.
`default_nettype none

module dqe_checker
  import dqe_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        done,
  input  logic signed [31:0]          value_out,
  input  logic [1:0]                  status,
  input  logic [$clog2(DEPTH+1)-1:0]  occupancy
);

  localparam logic [$clog2(DEPTH+1)-1:0] DEPTH_C = ($clog2(DEPTH+1))'(DEPTH);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("no result beat after accepted command");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result beat without accepted command");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> occupancy <= DEPTH_C)
    else $error("occupancy beyond depth");

  a_full_stat: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> occupancy == DEPTH_C && value_out == 32'sd0)
    else $error("full status with queue not full");

  a_empty_stat: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> occupancy == '0 && value_out == 32'sd0)
    else $error("empty status with queue not empty");

endmodule

bind double_ended_queue dqe_checker #(
  .DEPTH (DEPTH)
) u_dqe_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .value_out (value_out),
  .status    (status),
  .occupancy (occupancy)
);

`default_nettype wire
